[design/priority_affinity_run_queue_macros.svh]
// Assertion macros used by the run queue checker.
`ifndef PRIORITY_AFFINITY_RUN_QUEUE_MACROS_SVH
`define PRIORITY_AFFINITY_RUN_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PAR_CHECK_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PAR_CHECK_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[design/par_pkg.sv]
package par_pkg;
   localparam int THREADS = 64;
   localparam int LEVELS  = 32;
   localparam int CPUS    = 64;
   localparam int TID_W   = $clog2(THREADS);
   localparam int LVL_W   = $clog2(LEVELS);
   localparam int LINK_W  = TID_W + 1;
   localparam int CPU_W   = 6;
   localparam int AFF_W   = 64;
   localparam int ATTR_W  = LVL_W + AFF_W;
   localparam int CSR_IDX_W = 2;

   typedef logic [LINK_W-1:0] link_type;

   localparam link_type LINK_NONE = {1'b1, {TID_W{1'b0}}};
   localparam logic [AFF_W-1:0] ALL_CPUS = (CPUS >= AFF_W) ? {AFF_W{1'b1}} :
      ((AFF_W'(1) << (CPUS % AFF_W)) - AFF_W'(1));

   localparam logic [CSR_IDX_W-1:0] CSR_CPU_INDEX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_THREAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD        = 2'd2;

   localparam logic MODE_ENROLL = 1'b0;
   localparam logic MODE_TICK   = 1'b1;
endpackage

[design/par_ram.sv]
module par_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/priority_affinity_run_queue.sv]
// Rejected enrolls and postponed ticks go straight to the response; a tick first
// requeues an unqueued running thread, then scans the top level thread by thread.
// One request is worked at a time; the next is taken while a result waits.
// Reset is synchronous: queues empty, current thread 0, control registers zero; no
// clearing pass, the block is ready right after reset.
module priority_affinity_run_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [par_pkg::TID_W-1:0]     req_thread_id,
   input  logic [par_pkg::LVL_W-1:0]     req_priority_req,
   input  logic [par_pkg::AFF_W-1:0]     req_affinity,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [par_pkg::TID_W-1:0]     rsp_running_thread,
   output logic                          rsp_switched,
   output logic                          rsp_postponed,
   output logic                          rsp_idle_fallback,
   output logic                          rsp_rejected,
   input  logic                          csr_wr_en,
   input  logic [par_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [par_pkg::CPU_W-1:0]     csr_wr_data
);
   import par_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ENQ    = 4'd1;
   localparam logic [3:0] S_RDCUR  = 4'd2;
   localparam logic [3:0] S_CURDAT = 4'd3;
   localparam logic [3:0] S_APP1   = 4'd4;
   localparam logic [3:0] S_APP2   = 4'd5;
   localparam logic [3:0] S_SCAN0  = 4'd6;
   localparam logic [3:0] S_SCRD   = 4'd7;
   localparam logic [3:0] S_SCCHK  = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic              tick_ff, tick_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic [LVL_W-1:0]  prio_ff, prio_in;
   logic [AFF_W-1:0]  aff_ff, aff_in;
   logic [TID_W-1:0]  app_thread_ff, app_thread_in;
   logic [LVL_W-1:0]  app_lvl_ff, app_lvl_in;
   link_type          app_tail_ff, app_tail_in;
   logic [LVL_W-1:0]  scan_lvl_ff, scan_lvl_in;
   logic [TID_W-1:0]  scan_cur_ff, scan_cur_in;

   logic [THREADS-1:0] queued_ff, queued_in;
   logic [THREADS-1:0] attr_valid_ff, attr_valid_in;
   link_type           head_ff [LEVELS];
   link_type           head_in [LEVELS];
   link_type           tail_ff [LEVELS];
   link_type           tail_in [LEVELS];
   logic [LEVELS-1:0]  bitmap_ff, bitmap_in;
   logic [TID_W-1:0]   current_ff, current_in;

   logic [CPU_W-1:0]  cpu_index_ff, cpu_index_in;
   logic [TID_W-1:0]  idle_thread_ff, idle_thread_in;
   logic              hold_ff, hold_in;

   logic              res_sw_ff, res_sw_in;
   logic              res_post_ff, res_post_in;
   logic              res_idle_ff, res_idle_in;
   logic              res_rej_ff, res_rej_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TID_W-1:0]  rsp_thread_ff, rsp_thread_in;
   logic              rsp_sw_ff, rsp_sw_in;
   logic              rsp_post_ff, rsp_post_in;
   logic              rsp_idle_ff, rsp_idle_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic              next_wr_en, prev_wr_en, attr_wr_en;
   logic [TID_W-1:0]  next_wr_addr, prev_wr_addr, attr_wr_addr, rd_addr;
   link_type          next_wr_data, prev_wr_data, next_rd, prev_rd;
   logic [ATTR_W-1:0] attr_wr_data, attr_rd;

   logic [LVL_W-1:0]  top_lvl;
   logic              req_fire;
   logic              hit;
   link_type          cur_tail;
   link_type          new_head;

   par_ram #(.WIDTH(LINK_W), .DEPTH(THREADS)) u_next_ram (
      .clock(clock), .wr_en(next_wr_en), .wr_addr(next_wr_addr), .wr_data(next_wr_data),
      .rd_addr(rd_addr), .rd_data(next_rd)
   );
   par_ram #(.WIDTH(LINK_W), .DEPTH(THREADS)) u_prev_ram (
      .clock(clock), .wr_en(prev_wr_en), .wr_addr(prev_wr_addr), .wr_data(prev_wr_data),
      .rd_addr(rd_addr), .rd_data(prev_rd)
   );
   par_ram #(.WIDTH(ATTR_W), .DEPTH(THREADS)) u_attr_ram (
      .clock(clock), .wr_en(attr_wr_en), .wr_addr(attr_wr_addr), .wr_data(attr_wr_data),
      .rd_addr(rd_addr), .rd_data(attr_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // highest non-empty level
   always_comb begin
      top_lvl = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (bitmap_ff[i]) begin
            top_lvl = LVL_W'(i);
         end
      end
   end

   assign rd_addr  = (state_ff == S_RDCUR) ? current_ff : scan_cur_ff;
   assign cur_tail = tail_ff[app_lvl_ff];
   assign hit = attr_valid_ff[scan_cur_ff] ? attr_rd[cpu_index_ff] :
                ((scan_cur_ff == '0) && (cpu_index_ff == '0));
   assign new_head = prev_rd[TID_W] ? next_rd : head_ff[scan_lvl_ff];

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      tid_in        = tid_ff;
      prio_in       = prio_ff;
      aff_in        = aff_ff;
      app_thread_in = app_thread_ff;
      app_lvl_in    = app_lvl_ff;
      app_tail_in   = app_tail_ff;
      scan_lvl_in   = scan_lvl_ff;
      scan_cur_in   = scan_cur_ff;
      queued_in     = queued_ff;
      attr_valid_in = attr_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      bitmap_in     = bitmap_ff;
      current_in    = current_ff;
      res_sw_in     = res_sw_ff;
      res_post_in   = res_post_ff;
      res_idle_in   = res_idle_ff;
      res_rej_in    = res_rej_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_thread_in = rsp_thread_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_post_in   = rsp_post_ff;
      rsp_idle_in   = rsp_idle_ff;
      rsp_rej_in    = rsp_rej_ff;

      next_wr_en   = 1'b0;
      next_wr_addr = app_thread_ff;
      next_wr_data = LINK_NONE;
      prev_wr_en   = 1'b0;
      prev_wr_addr = app_thread_ff;
      prev_wr_data = cur_tail;
      attr_wr_en   = 1'b0;
      attr_wr_addr = tid_ff;
      attr_wr_data = {prio_ff, (aff_ff == '0) ? ALL_CPUS : aff_ff};

      cpu_index_in   = cpu_index_ff;
      idle_thread_in = idle_thread_ff;
      hold_in        = hold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CPU_INDEX:   cpu_index_in = csr_wr_data;
            CSR_IDLE_THREAD: idle_thread_in = csr_wr_data[TID_W-1:0];
            CSR_HOLD:        hold_in = csr_wr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               tick_in     = req_mode;
               tid_in      = req_thread_id;
               prio_in     = req_priority_req;
               aff_in      = req_affinity;
               res_sw_in   = 1'b0;
               res_post_in = 1'b0;
               res_idle_in = 1'b0;
               res_rej_in  = 1'b0;
               if (req_mode == MODE_ENROLL) begin
                  if (queued_ff[req_thread_id]) begin
                     res_rej_in = 1'b1;
                     state_in   = S_RESP;
                  end else begin
                     state_in = S_ENQ;
                  end
               end else if (hold_ff) begin
                  res_post_in = 1'b1;
                  state_in    = S_RESP;
               end else if (queued_ff[current_ff]) begin
                  state_in = S_SCAN0;
               end else begin
                  state_in = S_RDCUR;
               end
            end
         end
         S_ENQ: begin
            attr_wr_en            = 1'b1;
            attr_valid_in[tid_ff] = 1'b1;
            app_thread_in         = tid_ff;
            app_lvl_in            = prio_ff;
            state_in              = S_APP1;
         end
         S_RDCUR: begin
            state_in = S_CURDAT;
         end
         S_CURDAT: begin
            app_thread_in = current_ff;
            app_lvl_in    = attr_valid_ff[current_ff] ? attr_rd[ATTR_W-1:AFF_W] : '0;
            state_in      = S_APP1;
         end
         S_APP1: begin
            // link in at the tail; the old tail's forward link follows next
            prev_wr_en = 1'b1;
            next_wr_en = 1'b1;
            if (cur_tail[TID_W]) begin
               head_in[app_lvl_ff] = {1'b0, app_thread_ff};
            end
            tail_in[app_lvl_ff]      = {1'b0, app_thread_ff};
            bitmap_in[app_lvl_ff]    = 1'b1;
            queued_in[app_thread_ff] = 1'b1;
            app_tail_in              = cur_tail;
            state_in                 = S_APP2;
         end
         S_APP2: begin
            if (!app_tail_ff[TID_W]) begin
               next_wr_en   = 1'b1;
               next_wr_addr = app_tail_ff[TID_W-1:0];
               next_wr_data = {1'b0, app_thread_ff};
            end
            state_in = tick_ff ? S_SCAN0 : S_RESP;
         end
         S_SCAN0: begin
            res_sw_in = 1'b1;
            if (bitmap_ff == '0) begin
               res_idle_in = 1'b1;
               current_in  = idle_thread_ff;
               state_in    = S_RESP;
            end else begin
               scan_lvl_in = top_lvl;
               scan_cur_in = head_ff[top_lvl][TID_W-1:0];
               state_in    = S_SCRD;
            end
         end
         S_SCRD: begin
            state_in = S_SCCHK;
         end
         S_SCCHK: begin
            if (hit) begin
               // unlink the match
               if (!next_rd[TID_W]) begin
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = next_rd[TID_W-1:0];
                  prev_wr_data = prev_rd;
               end else begin
                  tail_in[scan_lvl_ff] = prev_rd;
               end
               if (!prev_rd[TID_W]) begin
                  next_wr_en   = 1'b1;
                  next_wr_addr = prev_rd[TID_W-1:0];
                  next_wr_data = next_rd;
               end else begin
                  head_in[scan_lvl_ff] = next_rd;
               end
               if (new_head[TID_W]) begin
                  bitmap_in[scan_lvl_ff] = 1'b0;
               end
               queued_in[scan_cur_ff] = 1'b0;
               current_in             = scan_cur_ff;
               state_in               = S_RESP;
            end else if (next_rd[TID_W]) begin
               res_idle_in = 1'b1;
               current_in  = idle_thread_ff;
               state_in    = S_RESP;
            end else begin
               scan_cur_in = next_rd[TID_W-1:0];
               state_in    = S_SCRD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_thread_in = current_ff;
               rsp_sw_in     = res_sw_ff;
               rsp_post_in   = res_post_ff;
               rsp_idle_in   = res_idle_ff;
               rsp_rej_in    = res_rej_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tick_ff       <= tick_in;
      tid_ff        <= tid_in;
      prio_ff       <= prio_in;
      aff_ff        <= aff_in;
      app_thread_ff <= app_thread_in;
      app_lvl_ff    <= app_lvl_in;
      app_tail_ff   <= app_tail_in;
      scan_lvl_ff   <= scan_lvl_in;
      scan_cur_ff   <= scan_cur_in;
      res_sw_ff     <= res_sw_in;
      res_post_ff   <= res_post_in;
      res_idle_ff   <= res_idle_in;
      res_rej_ff    <= res_rej_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_post_ff   <= rsp_post_in;
      rsp_idle_ff   <= rsp_idle_in;
      rsp_rej_ff    <= rsp_rej_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         queued_ff      <= '0;
         attr_valid_ff  <= '0;
         bitmap_ff      <= '0;
         current_ff     <= '0;
         cpu_index_ff   <= '0;
         idle_thread_ff <= '0;
         hold_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= LINK_NONE;
            tail_ff[i] <= LINK_NONE;
         end
      end else begin
         state_ff       <= state_in;
         queued_ff      <= queued_in;
         attr_valid_ff  <= attr_valid_in;
         bitmap_ff      <= bitmap_in;
         current_ff     <= current_in;
         cpu_index_ff   <= cpu_index_in;
         idle_thread_ff <= idle_thread_in;
         hold_ff        <= hold_in;
         rsp_valid_ff   <= rsp_valid_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_thread = rsp_thread_ff;
   assign rsp_switched       = rsp_sw_ff;
   assign rsp_postponed      = rsp_post_ff;
   assign rsp_idle_fallback  = rsp_idle_ff;
   assign rsp_rejected       = rsp_rej_ff;
endmodule

[design/par_checker.sv]
`include "priority_affinity_run_queue_macros.svh"

module par_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [par_pkg::TID_W-1:0] rsp_running_thread,
   input logic                      rsp_switched,
   input logic                      rsp_postponed,
   input logic                      rsp_idle_fallback,
   input logic                      rsp_rejected
);
   `PAR_CHECK_NOW(a_one_outcome, rsp_valid, $onehot0({rsp_switched, rsp_postponed, rsp_rejected}), "more than one outcome flag set")
   `PAR_CHECK_NOW(a_idle_is_switch, rsp_valid && rsp_idle_fallback, rsp_switched, "idle fallback without switch")
   `PAR_CHECK_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")
   `PAR_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_running_thread), "stalled response dropped")
endmodule

bind priority_affinity_run_queue par_checker u_par_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_running_thread(rsp_running_thread), .rsp_switched(rsp_switched),
   .rsp_postponed(rsp_postponed), .rsp_idle_fallback(rsp_idle_fallback),
   .rsp_rejected(rsp_rejected)
);
